[rtl/palette_color_indexer_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef PALETTE_COLOR_INDEXER_CORE_MACROS_SVH
`define PALETTE_COLOR_INDEXER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PCI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pci check failed");

// antecedent implies consequent in the next cycle
`define PCI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pci check failed");

`endif

[rtl/pci_pkg.sv]
package pci_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned InkW       = 12;
  localparam logic [InkW-1:0] MaxInk = 12'd4095;
  localparam logic [9:0]  L1Limit    = 10'd1000;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned DivSteps   = 8;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_OPAQ  = 2'd1;
  localparam logic [1:0] OP_ALIAS = 2'd2;

  localparam logic CFG_TOL   = 1'b0;
  localparam logic CFG_PLAIN = 1'b1;

  typedef struct packed {
    logic [1:0]      operation;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic [InkW-1:0] entry_index;
  } in_t;

  typedef struct packed {
    logic [InkW-1:0] ink_index;
    logic [7:0]      tone;
    logic            new_color;
    logic            no_room;
  } out_t;

  typedef struct packed {
    logic [7:0] tolerance;
    logic       plain;
  } cfg_t;

  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_OPAQUE,
    CMD_PLAIN,
    CMD_BG,
    CMD_AA
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [31:0]     key;
    logic [InkW-1:0] eidx;
    logic [7:0]      tone;
  } cmd_t;

  typedef struct packed {
    logic [31:0]     key;
    logic [InkW-1:0] ink;
  } entry_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_e;
  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_FINISH} back_state_e;

endpackage

[rtl/palette_color_indexer_core.sv]
// Palette color indexer: maps RGBA pixels to ink indices through a color table.
// Input: present pixel_i with start; the item transfers at a clock edge where
// start is high and busy is low. Operation 0 loads a table entry (no result),
// 1 is an opaque-pass pixel, 2 an antialias-pass pixel.
// Output: one result per handled pixel on result_o, valid for the single cycle
// that result_strobe_o is high. The receiver cannot stall the block.
// Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 tolerance, 1 plain ink
// mode) and cfg_data_i; ready is always high. Write only while idle.
// Scan: an item scans the table one entry per cycle through the single
// table read port; read data, compare results and best match are registered
// before the finish state. A plain-mode background pixel skips the scan;
// antialias pixels first pass the unmultiply divider and a queue push state.
// The back end takes one item at a time, loads too, popping only when idle.
// A two-entry command queue sits between classification and the table scan;
// busy holds the sender while it is full or the front divides or pushes.
// Reset empties the table (fill count zero), clears the highest and previous
// ink and both config registers; no clearing pass is needed.
module palette_color_indexer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  pci_pkg::in_t  pixel_i,
  output logic          busy,
  output logic          result_strobe_o,
  output pci_pkg::out_t result_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  pci_pkg::cfg_t cfg_q;
  pci_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pci_pkg::CFG_TOL:   cfg_q.tolerance <= cfg_data_i;
        pci_pkg::CFG_PLAIN: cfg_q.plain     <= cfg_data_i[0];
        default:            cfg_q           <= cfg_q;
      endcase
    end
  end

  pci_front u_front (
    .clk_i, .rst_ni, .start, .pixel_i,
    .plain_i    (cfg_q.plain),
    .full_i     (full),
    .busy,
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  pci_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .full_o     (full),
    .empty_o    (empty)
  );

  pci_back u_back (
    .clk_i, .rst_ni,
    .cfg_i    (cfg_q),
    .empty_i  (empty),
    .cmd_i    (pop_cmd),
    .pop_o    (pop),
    .strobe_o (result_strobe_o),
    .result_o
  );

endmodule

[rtl/pci_front.sv]
module pci_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  pci_pkg::in_t   pixel_i,
  input  logic           plain_i,
  input  logic           full_i,
  output logic           busy,
  output logic           push_o,
  output pci_pkg::cmd_t  push_cmd_o
);

  pci_pkg::front_state_e state_q, state_d;
  logic [2:0]    cnt_q;
  pci_pkg::cmd_t cmd_q;
  logic [7:0]    a_q;
  logic [7:0]    rem_q [3];
  logic [7:0]    lo_q  [3];
  logic [2:0]    sat_q;

  logic          accept;
  logic          keep;
  logic          need_div;
  pci_pkg::cmd_t cls;
  logic [7:0]    chan [3];
  logic [15:0]   num  [3];
  logic [8:0]    trial [3];

  assign accept = start && !busy;
  assign chan[0] = pixel_i.red;
  assign chan[1] = pixel_i.green;
  assign chan[2] = pixel_i.blue;

  always_comb begin
    logic [31:0] key;
    key = {pixel_i.red, pixel_i.green, pixel_i.blue, pixel_i.alpha};
    cls.key  = key;
    cls.eidx = pixel_i.entry_index;
    cls.tone = 8'd255 - pixel_i.alpha;
    cls.kind = pci_pkg::CMD_LOAD;
    keep     = 1'b0;
    need_div = 1'b0;
    unique case (pixel_i.operation)
      pci_pkg::OP_LOAD: begin
        keep = 1'b1;
      end
      pci_pkg::OP_OPAQ: begin
        if (plain_i) begin
          keep = 1'b1;
          cls.kind = (key == 32'hFFFF_FFFF || key == 32'h0) ? pci_pkg::CMD_BG
                                                             : pci_pkg::CMD_PLAIN;
        end else begin
          keep = (pixel_i.alpha == 8'hFF);
          cls.kind = pci_pkg::CMD_OPAQUE;
        end
      end
      pci_pkg::OP_ALIAS: begin
        cls.kind = pci_pkg::CMD_AA;
        need_div = (pixel_i.alpha != 8'h00) && (pixel_i.alpha != 8'hFF);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_num
    assign num[i]   = {chan[i], 8'h00} - {8'h00, chan[i]};
    assign trial[i] = {rem_q[i], lo_q[i][7]};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pci_pkg::F_IDLE: if (accept && need_div) state_d = pci_pkg::F_DIV;
      pci_pkg::F_DIV:  if (cnt_q == 3'(pci_pkg::DivSteps - 1)) state_d = pci_pkg::F_PUSH;
      pci_pkg::F_PUSH: if (!full_i) state_d = pci_pkg::F_IDLE;
      default:         state_d = pci_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_q != pci_pkg::F_IDLE) || full_i;
    push_o     = 1'b0;
    push_cmd_o = cls;
    unique case (state_q)
      pci_pkg::F_IDLE: push_o = accept && keep;
      pci_pkg::F_PUSH: begin
        push_o     = !full_i;
        push_cmd_o = cmd_q;
        push_cmd_o.key = {sat_q[0] ? 8'hFF : lo_q[0], sat_q[1] ? 8'hFF : lo_q[1],
                          sat_q[2] ? 8'hFF : lo_q[2], 8'hFF};
      end
      default: push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pci_pkg::F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_q == pci_pkg::F_DIV) ? cnt_q + 3'd1 : 3'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pci_pkg::F_IDLE && accept) begin
      cmd_q <= cls;
      a_q   <= pixel_i.alpha;
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= num[i][15:8];
        lo_q[i]  <= num[i][7:0];
        sat_q[i] <= (chan[i] >= pixel_i.alpha);
      end
    end else if (state_q == pci_pkg::F_DIV) begin
      for (int i = 0; i < 3; i++) begin
        if (trial[i] >= {1'b0, a_q}) begin
          rem_q[i] <= 8'(trial[i] - {1'b0, a_q});
          lo_q[i]  <= {lo_q[i][6:0], 1'b1};
        end else begin
          rem_q[i] <= trial[i][7:0];
          lo_q[i]  <= {lo_q[i][6:0], 1'b0};
        end
      end
    end
  end

endmodule

[rtl/pci_fifo.sv]
module pci_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pci_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output pci_pkg::cmd_t pop_cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  pci_pkg::cmd_t                 slot_q [pci_pkg::QDepth];
  logic [pci_pkg::QPtrW-1:0]     wptr_q, rptr_q;
  logic [pci_pkg::QPtrW:0]       cnt_q;

  assign full_o    = (cnt_q == (pci_pkg::QPtrW + 1)'(pci_pkg::QDepth));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= push_cmd_i;
  end

endmodule

[rtl/pci_back.sv]
module pci_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pci_pkg::cfg_t cfg_i,
  input  logic          empty_i,
  input  pci_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          strobe_o,
  output pci_pkg::out_t result_o
);

  localparam int unsigned IdxW = pci_pkg::IdxW;
  localparam int unsigned CntW = pci_pkg::CntW;

  pci_pkg::back_state_e state_q, state_d;
  pci_pkg::cmd_t   cmd_q;
  pci_pkg::entry_t mem [pci_pkg::TableDepth];
  pci_pkg::entry_t rd_q;
  logic [CntW-1:0] count_q, count_d, issue_q;
  logic [11:0]     high_q, high_d, prev_q, prev_d;
  logic            v1_q, v2_q;
  logic [IdxW-1:0] rdi_q, s_idx_q, ex_idx_q;
  logic [31:0]     s_key_q, bs_key_q;
  logic [11:0]     s_ink_q, ex_ink_q, bs_ink_q;
  logic            s_eq_q, s_cand_q, ex_found_q, bs_found_q;
  logic [17:0]     s_dist_q, bs_dist_q;
  logic            strobe_q;
  pci_pkg::out_t   res_q, res_d;
  logic            res_v;

  logic            issuing, scan_done;
  logic [7:0]      dr, dg, db;
  logic [15:0]     sr, sg, sb;
  logic [9:0]      l1;
  logic            cand;
  logic            better;
  logic            we;
  logic [IdxW-1:0] waddr;
  pci_pkg::entry_t wdata;
  logic            can_alloc, room;
  logic [11:0]     next_ink;

  assign issuing   = (state_q == pci_pkg::B_SCAN) && (issue_q < count_q);
  assign scan_done = (state_q == pci_pkg::B_SCAN) && !issuing && !v1_q && !v2_q;
  assign room      = (count_q < CntW'(pci_pkg::TableDepth));
  assign can_alloc = (high_q < pci_pkg::MaxInk) && room;
  assign next_ink  = high_q + 12'd1;

  function automatic logic [7:0] adiff(input logic [7:0] x, input logic [7:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  assign dr = adiff(rd_q.key[31:24], cmd_q.key[31:24]);
  assign dg = adiff(rd_q.key[23:16], cmd_q.key[23:16]);
  assign db = adiff(rd_q.key[15:8],  cmd_q.key[15:8]);
  assign sr = dr * dr;
  assign sg = dg * dg;
  assign sb = db * db;
  assign l1 = {2'b00, dr} + {2'b00, dg} + {2'b00, db};
  assign cand = (cmd_q.kind == pci_pkg::CMD_AA) ||
                ((cmd_q.kind == pci_pkg::CMD_OPAQUE) && (cfg_i.tolerance != 8'h00) &&
                 (dr <= cfg_i.tolerance) && (dg <= cfg_i.tolerance) &&
                 (db <= cfg_i.tolerance) && (l1 < pci_pkg::L1Limit));
  assign better = s_cand_q && (!bs_found_q || (s_dist_q < bs_dist_q) ||
                  ((s_dist_q == bs_dist_q) && (s_key_q < bs_key_q)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pci_pkg::B_IDLE: begin
        if (!empty_i) state_d = (cmd_i.kind == pci_pkg::CMD_BG) ? pci_pkg::B_FINISH
                                                                 : pci_pkg::B_SCAN;
      end
      pci_pkg::B_SCAN:   if (scan_done) state_d = pci_pkg::B_FINISH;
      pci_pkg::B_FINISH: state_d = pci_pkg::B_IDLE;
      default:           state_d = pci_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o   = (state_q == pci_pkg::B_IDLE) && !empty_i;
    we      = 1'b0;
    waddr   = count_q[IdxW-1:0];
    wdata   = '{key: cmd_q.key, ink: cmd_q.eidx};
    count_d = count_q;
    high_d  = high_q;
    prev_d  = prev_q;
    res_v   = 1'b0;
    res_d   = '0;
    if (state_q == pci_pkg::B_FINISH) begin
      unique case (cmd_q.kind)
        pci_pkg::CMD_LOAD: begin
          if (ex_found_q) begin
            we    = 1'b1;
            waddr = ex_idx_q;
          end else if (room) begin
            we      = 1'b1;
            count_d = count_q + 1'b1;
          end
          if ((ex_found_q || room) && cmd_q.eidx > high_q) high_d = cmd_q.eidx;
        end
        pci_pkg::CMD_BG: begin
          res_v = 1'b1;
          res_d.tone = 8'd255;
        end
        pci_pkg::CMD_OPAQUE, pci_pkg::CMD_PLAIN: begin
          res_v = 1'b1;
          if (ex_found_q) begin
            res_d.ink_index = ex_ink_q;
          end else if (cmd_q.kind == pci_pkg::CMD_OPAQUE && bs_found_q) begin
            res_d.ink_index = bs_ink_q;
            wdata.ink = bs_ink_q;
            if (room) begin
              we      = 1'b1;
              count_d = count_q + 1'b1;
            end
          end else if (can_alloc) begin
            high_d          = next_ink;
            wdata.ink       = next_ink;
            we              = 1'b1;
            count_d         = count_q + 1'b1;
            res_d.ink_index = next_ink;
            res_d.new_color = 1'b1;
          end else begin
            res_d.ink_index = (cmd_q.kind == pci_pkg::CMD_PLAIN) ? high_q : prev_q;
            res_d.no_room   = 1'b1;
          end
          prev_d = res_d.ink_index;
        end
        pci_pkg::CMD_AA: begin
          res_v = 1'b1;
          res_d.tone = cmd_q.tone;
          if (ex_found_q) begin
            res_d.ink_index = ex_ink_q;
          end else if (bs_found_q) begin
            res_d.ink_index = bs_ink_q;
          end else begin
            res_d.ink_index = prev_q;
            res_d.no_room   = 1'b1;
          end
        end
        default: res_v = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pci_pkg::B_IDLE;
      count_q  <= '0;
      high_q   <= '0;
      prev_q   <= '0;
      issue_q  <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      high_q   <= high_d;
      prev_q   <= prev_d;
      issue_q  <= issuing ? issue_q + 1'b1 : (pop_o ? '0 : issue_q);
      v1_q     <= issuing;
      v2_q     <= v1_q;
      strobe_q <= res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[issue_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    rdi_q    <= issue_q[IdxW-1:0];
    s_idx_q  <= rdi_q;
    s_key_q  <= rd_q.key;
    s_ink_q  <= rd_q.ink;
    s_eq_q   <= (rd_q.key == cmd_q.key);
    s_cand_q <= cand;
    s_dist_q <= (cmd_q.kind == pci_pkg::CMD_AA) ?
                ({2'b00, sr} + {2'b00, sg} + {2'b00, sb}) : {8'h00, l1};
    if (pop_o) begin
      cmd_q      <= cmd_i;
      ex_found_q <= 1'b0;
      bs_found_q <= 1'b0;
    end else if (v2_q) begin
      if (s_eq_q) begin
        ex_found_q <= 1'b1;
        ex_idx_q   <= s_idx_q;
        ex_ink_q   <= s_ink_q;
      end
      if (better) begin
        bs_found_q <= 1'b1;
        bs_dist_q  <= s_dist_q;
        bs_key_q   <= s_key_q;
        bs_ink_q   <= s_ink_q;
      end
    end
    if (res_v) res_q <= res_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

[rtl/pci_checker.sv]
`include "palette_color_indexer_core_macros.svh"

module pci_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          result_strobe_o,
  input pci_pkg::out_t result_o
);

  `PCI_ASSERT_NXT(a_strobe_gap, result_strobe_o, !result_strobe_o)
  `PCI_ASSERT_IMP(a_new_not_full, result_strobe_o && result_o.no_room, !result_o.new_color)
  `PCI_ASSERT_IMP(a_new_tone, result_strobe_o && result_o.new_color, result_o.tone == 8'd0)

endmodule

bind palette_color_indexer_core pci_checker u_pci_checker (
  .clk_i, .rst_ni, .result_strobe_o, .result_o
);

[bench/palette_color_indexer_core_test.sv]
module palette_color_indexer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpIgnored = 2'd3;

  class ink_scoreboard;
    logic [31:0]              color_key [pci_pkg::TableDepth];
    logic [pci_pkg::InkW-1:0] color_ink [pci_pkg::TableDepth];
    int unsigned     fill;
    int unsigned     top_ink;
    int unsigned     last_ink;
    int unsigned     tolerance;
    bit              plain;
    pci_pkg::out_t   inks_due [$];
    int unsigned     errors;
    int unsigned     pixels;
    int unsigned     loads;
    int unsigned     results;

    function int find_key(logic [31:0] key);
      for (int i = 0; i < fill; i++) if (color_key[i] == key) return i;
      return -1;
    endfunction

    function int unsigned adiff(int unsigned x, int unsigned y);
      return (x > y) ? x - y : y - x;
    endfunction

    function int find_near(logic [31:0] key, bit squared);
      int best;
      int unsigned bestd, dr, dg, db, d;
      best = -1;
      bestd = 0;
      for (int i = 0; i < fill; i++) begin
        dr = adiff(color_key[i][31:24], key[31:24]);
        dg = adiff(color_key[i][23:16], key[23:16]);
        db = adiff(color_key[i][15:8], key[15:8]);
        if (squared) begin
          d = dr * dr + dg * dg + db * db;
        end else begin
          if (dr > tolerance || dg > tolerance || db > tolerance) continue;
          d = dr + dg + db;
          if (d >= 1000) continue;
        end
        if (best < 0 || d < bestd || (d == bestd && color_key[i] < color_key[best])) begin
          best = i;
          bestd = d;
        end
      end
      return best;
    endfunction

    function void add_entry(logic [31:0] key, int unsigned ink);
      if (fill >= pci_pkg::TableDepth) return;
      color_key[fill] = key;
      color_ink[fill] = ink[pci_pkg::InkW-1:0];
      fill++;
    endfunction

    function bit room_left();
      return top_ink < pci_pkg::MaxInk && fill < pci_pkg::TableDepth;
    endfunction

    function void note(pci_pkg::in_t it);
      logic [31:0] key, ukey;
      int s;
      int unsigned ur, ug, ub;
      pci_pkg::out_t o;
      key = {it.red, it.green, it.blue, it.alpha};
      o = '0;
      if (it.operation == pci_pkg::OP_LOAD) begin
        loads++;
        s = find_key(key);
        if (s >= 0) color_ink[s] = it.entry_index;
        else if (fill >= pci_pkg::TableDepth) return;
        else add_entry(key, it.entry_index);
        if (it.entry_index > top_ink) top_ink = it.entry_index;
        return;
      end
      if (it.operation == pci_pkg::OP_OPAQ) begin
        if (plain) begin
          s = find_key(key);
          if (key == 32'hFFFF_FFFF || key == 32'h0) begin
            o.tone = 8'd255;
          end else if (s >= 0) begin
            o.ink_index = color_ink[s];
            last_ink = o.ink_index;
          end else if (room_left()) begin
            top_ink++;
            add_entry(key, top_ink);
            o.ink_index = top_ink[pci_pkg::InkW-1:0];
            o.new_color = 1'b1;
            last_ink = top_ink;
          end else begin
            o.ink_index = top_ink[pci_pkg::InkW-1:0];
            o.no_room = 1'b1;
            last_ink = top_ink;
          end
        end else begin
          if (it.alpha != 8'd255) return;
          s = find_key(key);
          if (s < 0 && tolerance > 0) begin
            s = find_near(key, 1'b0);
            if (s >= 0) begin
              o.ink_index = color_ink[s];
              add_entry(key, o.ink_index);
            end
          end else if (s >= 0) begin
            o.ink_index = color_ink[s];
          end
          if (s < 0) begin
            if (room_left()) begin
              top_ink++;
              add_entry(key, top_ink);
              o.ink_index = top_ink[pci_pkg::InkW-1:0];
              o.new_color = 1'b1;
            end else begin
              o.ink_index = last_ink[pci_pkg::InkW-1:0];
              o.no_room = 1'b1;
            end
          end
          last_ink = o.ink_index;
        end
      end else if (it.operation == pci_pkg::OP_ALIAS) begin
        if (it.alpha == 8'd0 || it.alpha == 8'd255) return;
        ur = it.red * 255 / it.alpha;
        ug = it.green * 255 / it.alpha;
        ub = it.blue * 255 / it.alpha;
        if (ur > 255) ur = 255;
        if (ug > 255) ug = 255;
        if (ub > 255) ub = 255;
        ukey = {ur[7:0], ug[7:0], ub[7:0], 8'hFF};
        s = find_key(ukey);
        if (s < 0) s = find_near(ukey, 1'b1);
        if (s >= 0) begin
          o.ink_index = color_ink[s];
        end else begin
          o.ink_index = last_ink[pci_pkg::InkW-1:0];
          o.no_room = 1'b1;
        end
        o.tone = 8'd255 - it.alpha;
      end else begin
        return;
      end
      pixels++;
      inks_due = {inks_due, o};
    endfunction

    function void check(pci_pkg::out_t got);
      pci_pkg::out_t exp;
      results++;
      if (inks_due.size() == 0) begin
        $error("unexpected result ink_index=%0d", got.ink_index);
        errors++;
        return;
      end
      exp = inks_due.pop_front();
      if (got.ink_index !== exp.ink_index) begin
        $error("ink_index: expected %0d, got %0d", exp.ink_index, got.ink_index);
        errors++;
      end
      if (got.tone !== exp.tone) begin
        $error("tone: expected %0d, got %0d", exp.tone, got.tone);
        errors++;
      end
      if (got.new_color !== exp.new_color) begin
        $error("new_color: expected %0b, got %0b", exp.new_color, got.new_color);
        errors++;
      end
      if (got.no_room !== exp.no_room) begin
        $error("no_room: expected %0b, got %0b", exp.no_room, got.no_room);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  pci_pkg::in_t  pixel_i;
  logic busy;
  logic result_strobe_o;
  pci_pkg::out_t result_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_index_i;
  logic [7:0] cfg_data_i;

  ink_scoreboard sb;
  int unsigned   idle_pct;
  logic [23:0]   swatch [8];

  palette_color_indexer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .pixel_i         (pixel_i),
    .busy            (busy),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check(result_o);
  end

  function automatic pci_pkg::in_t mk(logic [1:0] op, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b, logic [7:0] a, logic [11:0] e);
    pci_pkg::in_t it;
    it.operation = op;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.alpha = a;
    it.entry_index = e;
    return it;
  endfunction

  task automatic send(pci_pkg::in_t it);
    pixel_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note(it);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (sb.inks_due.size() != 0) @(posedge clk_i);
    repeat (4 * sb.fill + 64) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == pci_pkg::CFG_TOL) sb.tolerance = data;
    else sb.plain = data[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic pci_pkg::in_t rand_item(bit wide_loads);
    pci_pkg::in_t it;
    logic [23:0] c;
    int unsigned pick;
    it = pci_pkg::in_t'({$urandom, $urandom});
    c = swatch[$urandom_range(0, 7)];
    pick = $urandom_range(0, 99);
    if (pick < 15) c = 24'($urandom);
    else if (pick < 55) c = c ^ 24'($urandom_range(0, 7) << (8 * $urandom_range(0, 2)));
    {it.red, it.green, it.blue} = c;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.operation = pci_pkg::OP_LOAD;
      it.alpha = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF;
      if (!wide_loads || $urandom_range(0, 5) != 0) begin
        it.entry_index = 12'($urandom_range(1, 80));
      end
    end else if (pick < 65) begin
      it.operation = pci_pkg::OP_OPAQ;
      if ($urandom_range(0, 9) != 0) it.alpha = 8'hFF;
    end else if (pick < 95) begin
      it.operation = pci_pkg::OP_ALIAS;
    end else begin
      it.operation = OpIgnored;
    end
    return it;
  endfunction

  task automatic random_phase(int unsigned n, logic [7:0] tol, bit pl, int unsigned pct,
                              bit wide_loads);
    wait_quiet();
    write_cfg(pci_pkg::CFG_TOL, tol);
    write_cfg(pci_pkg::CFG_PLAIN, {7'd0, pl});
    idle_pct = pct;
    repeat (n) send(rand_item(wide_loads));
  endtask

  initial begin
    sb = new();
    start = 1'b0;
    pixel_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = pci_pkg::CFG_TOL;
    cfg_data_i = '0;
    idle_pct = 12;
    foreach (swatch[i]) swatch[i] = 24'($urandom);
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(pci_pkg::CFG_TOL, 8'd0);
    write_cfg(pci_pkg::CFG_PLAIN, 8'd0);
    send(mk(pci_pkg::OP_ALIAS, 8'd128, 8'd64, 8'd32, 8'd100, 12'd0));
    send(mk(pci_pkg::OP_OPAQ, 8'd10, 8'd20, 8'd30, 8'd254, 12'hFFF));
    send(mk(OpIgnored, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF));
    send(mk(pci_pkg::OP_OPAQ, 8'd10, 8'd20, 8'd30, 8'd255, 12'd0));
    send(mk(pci_pkg::OP_OPAQ, 8'd10, 8'd20, 8'd30, 8'd255, 12'd0));
    send(mk(pci_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 8'd255, 12'd7));
    send(mk(pci_pkg::OP_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 12'd0));
    send(mk(pci_pkg::OP_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 12'd9));
    send(mk(pci_pkg::OP_OPAQ, 8'd11, 8'd20, 8'd30, 8'd255, 12'd0));
    wait_quiet();
    write_cfg(pci_pkg::CFG_TOL, 8'd5);
    send(mk(pci_pkg::OP_OPAQ, 8'd12, 8'd21, 8'd31, 8'd255, 12'd0));
    send(mk(pci_pkg::OP_OPAQ, 8'd200, 8'd200, 8'd200, 8'd255, 12'd0));
    send(mk(pci_pkg::OP_ALIAS, 8'd5, 8'd10, 8'd15, 8'd128, 12'd0));
    send(mk(pci_pkg::OP_ALIAS, 8'd1, 8'd0, 8'd0, 8'd1, 12'd0));
    send(mk(pci_pkg::OP_ALIAS, 8'd255, 8'd255, 8'd255, 8'd254, 12'd0));
    send(mk(pci_pkg::OP_ALIAS, 8'd0, 8'd0, 8'd0, 8'd0, 12'd0));
    wait_quiet();
    write_cfg(pci_pkg::CFG_PLAIN, 8'd1);
    send(mk(pci_pkg::OP_OPAQ, 8'd255, 8'd255, 8'd255, 8'd255, 12'd0));
    send(mk(pci_pkg::OP_OPAQ, 8'd0, 8'd0, 8'd0, 8'd0, 12'd0));
    send(mk(pci_pkg::OP_OPAQ, 8'd10, 8'd20, 8'd30, 8'd255, 12'd0));
    send(mk(pci_pkg::OP_OPAQ, 8'd1, 8'd2, 8'd3, 8'd4, 12'd0));
    send(mk(pci_pkg::OP_ALIAS, 8'd100, 8'd50, 8'd25, 8'd200, 12'd0));

    random_phase(30, 8'd255, 1'b0, 12, 1'b0);
    random_phase(30, 8'd7, 1'b1, 79, 1'b0);
    random_phase(30, 8'd0, 1'b0, 0, 1'b0);
    random_phase(30, 8'd40, 1'b0, 0, 1'b1);

    wait_quiet();
    $display("Covered %0d loads and %0d pixel results; table held %0d entries, top ink %0d.",
             sb.loads, sb.results, sb.fill, sb.top_ink);
    $display("Tolerance 0/5/7/40/255, plain ink on and off, with and without sender gaps.");
    if (sb.errors == 0 && sb.inks_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/pci_pkg.sv
rtl/pci_front.sv
rtl/pci_fifo.sv
rtl/pci_back.sv
rtl/palette_color_indexer_core.sv
rtl/pci_checker.sv
bench/palette_color_indexer_core_test.sv
